// ===== hdl/ultrasonic_tof_ranger_unit_defines.svh =====
// Assertion macros for the ultrasonic time-of-flight ranger.
// Depends on nothing; used by the checker, which supplies clk and rst_n in scope.
`ifndef ULTRASONIC_TOF_RANGER_UNIT_DEFINES_SVH
`define ULTRASONIC_TOF_RANGER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utr_pkg.sv =====
// Shared types and constants of the ultrasonic time-of-flight ranger.
// No dependencies; imported by every module of the block.
package utr_pkg;

  // Word carried by the input channel: one microsecond tick
  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_word_t;

  // Word carried by the result channel
  typedef struct packed {
    logic        tx_gate;
    logic        busy_res;
    logic        done_res;
    logic        echo_found;
    logic [13:0] flight_us;
    logic [11:0] distance_q4;
  } out_word_t;

  // Tick result before distance scaling
  typedef struct packed {
    logic        tx_gate;
    logic        busy_res;
    logic        done_res;
    logic        echo_found;
    logic [13:0] flight_us;
  } mid_word_t;

  // Measurement phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_TX     = 4'b0010,
    PH_BLIND  = 4'b0100,
    PH_LISTEN = 4'b1000
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] REG_TX_TICKS      = 2'd0;
  localparam logic [1:0] REG_BLIND_TICKS   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;

  // Register reset values
  localparam logic [11:0] TX_TICKS_RST      = 12'd500;
  localparam logic [11:0] BLIND_TICKS_RST   = 12'd250;
  localparam logic [12:0] TIMEOUT_TICKS_RST = 13'd3500;

  // distance_q4 = floor(flight*16/58) = floor((flight*8)/29).
  // Reciprocal ceil(2^22/29) is exact for numerators below 174762; ours stay under 98289.
  localparam logic [17:0] RECIP_29    = 18'd144632;
  localparam int          RECIP_SHIFT = 22;

endpackage

// ===== hdl/ultrasonic_tof_ranger_unit.sv =====
// Top level of the ultrasonic time-of-flight ranger.
// Depends on utr_pkg, utr_ctrl and utr_scale.
//
//   channel  | handshake            | word
//   ---------+----------------------+--------------------------------------
//   in       | in_valid / in_ready  | in_word   (one microsecond tick)
//   out      | out_valid / out_ready| out_word  (one result per tick)
//   cfg      | cfg_we               | cfg_addr, cfg_wdata (no read-back)
//
// One tick word per cycle sustained while the output is not stalled; each result passes
// through the stage-one and output registers. The phase counter steps once per accepted
// word; the divide by 58 is a 17x18 multiply in the second stage.
// Reset is synchronous: idle phase, counters clear, registers to defaults.
// A stalled output holds its word; the first stage keeps accepting until it also fills.
module ultrasonic_tof_ranger_unit
  import utr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic      in_fire;
  logic      s1_free;
  mid_word_t mid_nxt;

  assign in_ready = s1_free;
  assign in_fire  = in_valid && s1_free;

  // Phase sequencer and flight time
  utr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mid_nxt   (mid_nxt)
  );

  // Distance scaling and output stage
  utr_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .mid_nxt   (mid_nxt),
    .s1_free   (s1_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ===== hdl/utr_ctrl.sv =====
// Measurement sequencer: config registers, phase/counter state, edge detect, flight time.
// Depends on utr_pkg.
module utr_ctrl
  import utr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  in_word_t          in_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output mid_word_t         mid_nxt
);

  logic [11:0] tx_ticks_r;
  logic [11:0] blind_ticks_r;
  logic [12:0] timeout_ticks_r;

  phase_t      phase_r, phase_nxt;
  logic [12:0] phase_count_r, phase_count_nxt;
  logic        last_echo_r;

  phase_t      cur_phase;
  logic [12:0] cur_count;
  logic [12:0] cnt_inc;
  logic        start_now;
  logic        rising;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_ticks_r      <= TX_TICKS_RST;
      blind_ticks_r   <= BLIND_TICKS_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TX_TICKS:      tx_ticks_r      <= cfg_wdata[11:0];
        REG_BLIND_TICKS:   blind_ticks_r   <= cfg_wdata[11:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A start seen in idle makes this tick the first transmit tick
  assign start_now = (phase_r == PH_IDLE) && in_word.start_req;
  assign cur_phase = start_now ? PH_TX : phase_r;
  assign cur_count = start_now ? 13'd0 : phase_count_r;
  assign cnt_inc   = cur_count + 13'd1;
  assign rising    = in_word.echo_level && !last_echo_r;

  // Per-tick phase step
  always_comb begin
    phase_nxt       = cur_phase;
    phase_count_nxt = cur_count;
    mid_nxt         = '0;
    unique case (cur_phase)
      PH_IDLE: ;
      PH_TX: begin
        mid_nxt.tx_gate  = 1'b1;
        mid_nxt.busy_res = 1'b1;
        phase_count_nxt  = cnt_inc;
        if (cnt_inc >= {1'b0, tx_ticks_r}) begin
          phase_nxt       = (blind_ticks_r == 12'd0) ? PH_LISTEN : PH_BLIND;
          phase_count_nxt = 13'd0;
        end
      end
      PH_BLIND: begin
        mid_nxt.busy_res = 1'b1;
        phase_count_nxt  = cnt_inc;
        if (cnt_inc >= {1'b0, blind_ticks_r}) begin
          phase_nxt       = PH_LISTEN;
          phase_count_nxt = 13'd0;
        end
      end
      PH_LISTEN: begin
        if (rising) begin
          // first echo edge: capture flight time
          mid_nxt.done_res   = 1'b1;
          mid_nxt.echo_found = 1'b1;
          mid_nxt.flight_us  = {2'b00, blind_ticks_r} + {1'b0, cur_count};
          phase_nxt          = PH_IDLE;
          phase_count_nxt    = 13'd0;
        end else if (cnt_inc >= timeout_ticks_r) begin
          mid_nxt.done_res = 1'b1;
          phase_nxt        = PH_IDLE;
          phase_count_nxt  = 13'd0;
        end else begin
          mid_nxt.busy_res = 1'b1;
          phase_count_nxt  = cnt_inc;
        end
      end
      default: begin
        phase_nxt       = PH_IDLE;
        phase_count_nxt = 13'd0;
      end
    endcase
  end

  // State advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      phase_count_r <= 13'd0;
      last_echo_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      phase_count_r <= phase_count_nxt;
      last_echo_r   <= in_word.echo_level;
    end
  end

endmodule

// ===== hdl/utr_scale.sv =====
// Tick result register, distance scaling by reciprocal multiply, and output register.
// Depends on utr_pkg.
module utr_scale
  import utr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  mid_word_t mid_nxt,
  output logic      s1_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  mid_word_t   s1_r;
  logic        s1_valid_r;
  out_word_t   out_r;
  logic        out_valid_r;
  logic        s2_load;
  logic [16:0] numer;
  logic [34:0] prod;

  // Stage two loads when the output register is empty or being drained
  assign s2_load = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_free = !s1_valid_r || s2_load;

  // Stage one: registered tick result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= mid_nxt;
    end
  end

  // flight*8 times reciprocal of 29, upper bits give the Q4 distance
  assign numer = {s1_r.flight_us, 3'b000};
  assign prod  = {18'd0, numer} * {17'd0, RECIP_29};

  // Stage two: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_r.tx_gate     <= s1_r.tx_gate;
      out_r.busy_res    <= s1_r.busy_res;
      out_r.done_res    <= s1_r.done_res;
      out_r.echo_found  <= s1_r.echo_found;
      out_r.flight_us   <= s1_r.flight_us;
      out_r.distance_q4 <= prod[RECIP_SHIFT+11:RECIP_SHIFT];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// ===== hdl/utr_checker.sv =====
// Port-level checker of the ultrasonic time-of-flight ranger, bound to the top level.
// Depends on utr_pkg and ultrasonic_tof_ranger_unit_defines.svh.
`include "ultrasonic_tof_ranger_unit_defines.svh"

module utr_checker
  import utr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // A stalled result word holds
  `UTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

  // Transmit ticks are busy and never finish a measurement
  `UTR_ASSERT_NOW(a_tx_busy, out_valid && out_word.tx_gate, out_word.busy_res && !out_word.done_res, "tx_gate without busy or with done")

  // Busy and done never together
  `UTR_ASSERT_NOW(a_busy_done, out_valid && out_word.done_res, !out_word.busy_res, "busy and done in the same word")

  // Measurement fields are zero unless an echo was found
  `UTR_ASSERT_NOW(a_zero_fields, out_valid && !out_word.echo_found, out_word.flight_us == 14'd0 && out_word.distance_q4 == 12'd0, "nonzero range without an echo")

endmodule

bind ultrasonic_tof_ranger_unit utr_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_tof_ranger_unit: directed tick table, then randomized
// measurements over several register settings, checked against a cycle-free tick predictor.
// Depends on utr_pkg and the RTL of the ranger only.
module tb;
  import utr_pkg::*;

  localparam int LIMIT_CYCLES    = 1500000;
  localparam int SETTLE_CYCLES   = 6;    // two-stage pipe plus margin
  localparam int HOLD_OFF_AFTER  = 400;  // words sent before the long output stall
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_FIXED       = 5;
  localparam int NUM_RANDOM      = 4;

  // Tick words: {start_req, echo_level}
  localparam in_word_t TK_QUIET = 2'b00;
  localparam in_word_t TK_ECHO  = 2'b01;
  localparam in_word_t TK_START = 2'b10;
  localparam in_word_t TK_BOTH  = 2'b11;

  // Result words that can be read off directly
  localparam out_word_t OUT_IDLE  = '0;
  localparam out_word_t OUT_TX    = '{1'b1, 1'b1, 1'b0, 1'b0, 14'd0, 12'd0};
  localparam out_word_t OUT_BUSY  = '{1'b0, 1'b1, 1'b0, 1'b0, 14'd0, 12'd0};
  localparam out_word_t OUT_MISS  = '{1'b0, 1'b0, 1'b1, 1'b0, 14'd0, 12'd0};
  localparam out_word_t OUT_HIT0  = '{1'b0, 1'b0, 1'b1, 1'b1, 14'd0, 12'd0};
  localparam out_word_t OUT_HIT4  = '{1'b0, 1'b0, 1'b1, 1'b1, 14'd4, 12'd1};

  typedef enum int {ECHO_CLEAN, ECHO_PREHIGH, ECHO_NOISE, ECHO_SILENT} echo_plan_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

  typedef struct packed {
    logic              wr;     // 1: register write row, 0: tick row
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
    in_word_t          tick;
    logic              typed;  // 1: use exp below, 0: use the predictor
    out_word_t         exp;
  } dir_row_t;

  typedef struct {
    int tx;
    int blind;
    int tmo;
    int n;
  } setting_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_word;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  ultrasonic_tof_ranger_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Directed ticks; a write row first lets the running measurement finish
  dir_row_t dir_rows [25] = '{
    // reset settings: idle ticks with and without echo
    '{1'b0, REG_TX_TICKS, 13'd0, TK_QUIET, 1'b1, OUT_IDLE},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_ECHO,  1'b1, OUT_IDLE},
    // zero burst and zero timeout behave as one tick; echo already high is no edge
    '{1'b1, REG_TX_TICKS,      13'd0, TK_QUIET, 1'b0, OUT_IDLE},
    '{1'b1, REG_BLIND_TICKS,   13'd0, TK_QUIET, 1'b0, OUT_IDLE},
    '{1'b1, REG_TIMEOUT_TICKS, 13'd0, TK_QUIET, 1'b0, OUT_IDLE},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_BOTH,  1'b1, OUT_TX},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_BOTH,  1'b1, OUT_MISS},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_QUIET, 1'b1, OUT_IDLE},
    // short burst and blind window; edges in burst and blind are ignored
    '{1'b1, REG_TX_TICKS,      13'd2, TK_QUIET, 1'b0, OUT_IDLE},
    '{1'b1, REG_BLIND_TICKS,   13'd3, TK_QUIET, 1'b0, OUT_IDLE},
    '{1'b1, REG_TIMEOUT_TICKS, 13'd5, TK_QUIET, 1'b0, OUT_IDLE},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_START, 1'b1, OUT_TX},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_BOTH,  1'b1, OUT_TX},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_QUIET, 1'b1, OUT_BUSY},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_ECHO,  1'b1, OUT_BUSY},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_QUIET, 1'b1, OUT_BUSY},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_QUIET, 1'b1, OUT_BUSY},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_ECHO,  1'b1, OUT_HIT4},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_BOTH,  1'b0, OUT_IDLE},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_QUIET, 1'b0, OUT_IDLE},
    // no blind window: edge on the first listen tick
    '{1'b1, REG_BLIND_TICKS,   13'd0, TK_QUIET, 1'b0, OUT_IDLE},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_START, 1'b1, OUT_TX},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_QUIET, 1'b1, OUT_TX},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_ECHO,  1'b1, OUT_HIT0},
    '{1'b0, REG_TX_TICKS, 13'd0, TK_BOTH,  1'b0, OUT_IDLE}
  };

  // shortest, small, longest timeout, zero blind with long listen, long blind with short listen
  setting_t fixed_set [NUM_FIXED] = '{
    '{1, 0, 1, 100},
    '{3, 2, 16, 120},
    '{24, 40, 8191, 30},
    '{2, 0, 8191, 30},
    '{1, 100, 64, 60}
  };

  // Ranger state as the predictor sees it
  phase_t      ph = PH_IDLE;
  logic [12:0] ph_cnt = '0;
  logic        echo_prev = 1'b0;
  logic [11:0] tx_len = TX_TICKS_RST;
  logic [11:0] blind_len = BLIND_TICKS_RST;
  logic [12:0] listen_len = TIMEOUT_TICKS_RST;
  int          run_no = 0;

  // Echo shaping of the current measurement
  echo_plan_t  echo_plan = ECHO_CLEAN;
  int          echo_at = 0;
  int          echo_hold = 0;
  int          planned_run = 0;

  out_word_t   pending_results [$];
  int          burst_left = 0;
  int          words_sent = 0;
  int          fail_cnt = 0;

  // One microsecond tick of the ranger
  function automatic out_word_t ranger_tick(in_word_t w);
    out_word_t   r;
    logic        rising;
    int unsigned flight;
    r = '0;
    rising = w.echo_level && !echo_prev;
    if (ph == PH_IDLE && w.start_req) begin
      ph = PH_TX;
      ph_cnt = '0;
      run_no++;
    end
    case (ph)
      PH_TX: begin
        r.tx_gate = 1'b1;
        r.busy_res = 1'b1;
        ph_cnt = ph_cnt + 13'd1;
        if (ph_cnt >= tx_len) begin
          ph = (blind_len == '0) ? PH_LISTEN : PH_BLIND;
          ph_cnt = '0;
        end
      end
      PH_BLIND: begin
        r.busy_res = 1'b1;
        ph_cnt = ph_cnt + 13'd1;
        if (ph_cnt >= blind_len) begin
          ph = PH_LISTEN;
          ph_cnt = '0;
        end
      end
      PH_LISTEN: begin
        if (rising) begin
          flight = blind_len + ph_cnt;
          r.done_res = 1'b1;
          r.echo_found = 1'b1;
          r.flight_us = flight[13:0];
          r.distance_q4 = 12'((32'(r.flight_us) * 16) / 58);
          ph = PH_IDLE;
          ph_cnt = '0;
        end else begin
          ph_cnt = ph_cnt + 13'd1;
          if (ph_cnt >= listen_len) begin
            r.done_res = 1'b1;
            ph = PH_IDLE;
            ph_cnt = '0;
          end else begin
            r.busy_res = 1'b1;
          end
        end
      end
      default: ;
    endcase
    echo_prev = w.echo_level;
    return r;
  endfunction

  // Next tick word; half of the measurements get a clean echo at a random listen offset
  function automatic in_word_t next_tick(bit winding_down);
    in_word_t w;
    int       idx;
    int       span;
    int       pick;
    w.echo_level = 1'($urandom_range(0, 1));
    if (ph == PH_IDLE) begin
      w.start_req = !winding_down && ($urandom_range(0, 2) == 0);
      return w;
    end
    w.start_req = winding_down ? 1'b0 : 1'($urandom_range(0, 1));
    if (planned_run != run_no) begin
      planned_run = run_no;
      span = (listen_len == '0) ? 1 : int'(listen_len);
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        echo_plan = ECHO_CLEAN;
        echo_at = $urandom_range(0, span + span / 8 + 1);
      end else if (pick < 14) begin
        echo_plan = ECHO_PREHIGH;
        echo_hold = $urandom_range(1, 4);
        echo_at = echo_hold + $urandom_range(1, span);
      end else if (pick < 17) begin
        echo_plan = ECHO_NOISE;
      end else begin
        echo_plan = ECHO_SILENT;
      end
    end
    idx = (ph == PH_LISTEN) ? int'(ph_cnt) : -1;
    case (echo_plan)
      ECHO_CLEAN:   if (idx >= 0) w.echo_level = (idx >= echo_at);
      ECHO_PREHIGH: w.echo_level = (idx < echo_hold) || (idx >= echo_at);
      ECHO_NOISE:   if (idx >= 0) w.echo_level = ($urandom_range(0, 3) == 0);
      default:      if (idx >= 0) w.echo_level = 1'b0;
    endcase
    // Winding down: toggle the echo each tick so a rising edge soon ends listening
    if (winding_down && ph == PH_LISTEN) w.echo_level = !echo_prev;
    return w;
  endfunction

  // Offer one word in bursts with random gaps; predict on acceptance
  task automatic send_tick(in_word_t w, bit typed, out_word_t typed_exp);
    out_word_t pred;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    pred = ranger_tick(w);
    pending_results.push_back(typed ? typed_exp : pred);
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_DW'(value);
    case (idx)
      REG_TX_TICKS:      tx_len = 12'(value);
      REG_BLIND_TICKS:   blind_len = 12'(value);
      REG_TIMEOUT_TICKS: listen_len = 13'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Finish the running measurement and drain all results
  task automatic go_idle();
    while (ph != PH_IDLE) send_tick(next_tick(1'b1), 1'b0, OUT_IDLE);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed table, then random measurements per setting
  initial begin
    setting_t s;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        go_idle();
        write_reg(dir_rows[i].addr, int'(dir_rows[i].data));
      end else begin
        send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].exp);
      end
    end
    for (int p = 0; p < NUM_FIXED + NUM_RANDOM; p++) begin
      if (p < NUM_FIXED) begin
        s = fixed_set[p];
      end else begin
        s = '{int'($urandom_range(1, 12)), int'($urandom_range(0, 12)),
              int'($urandom_range(1, 48)), 40};
      end
      go_idle();
      write_reg(REG_TX_TICKS, s.tx);
      write_reg(REG_BLIND_TICKS, s.blind);
      write_reg(REG_TIMEOUT_TICKS, s.tmo);
      for (int k = 0; k < s.n; k++) send_tick(next_tick(1'b0), 1'b0, OUT_IDLE);
    end
    go_idle();
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output stall patterns, with one long hold-off to back up the pipe
  initial begin : drive_ready
    rx_pattern_t mode;
    int          left;
    bit          held;
    mode = RX_OPEN;
    left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = rx_pattern_t'($urandom_range(0, 3));
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= left[0];
      endcase
    end
  end

  function automatic void note_bad(string what, int want, int got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("result word %h with none expected", out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word.tx_gate !== want.tx_gate)
          note_bad("tx_gate", want.tx_gate, out_word.tx_gate);
        if (out_word.busy_res !== want.busy_res)
          note_bad("busy_res", want.busy_res, out_word.busy_res);
        if (out_word.done_res !== want.done_res)
          note_bad("done_res", want.done_res, out_word.done_res);
        if (out_word.echo_found !== want.echo_found)
          note_bad("echo_found", want.echo_found, out_word.echo_found);
        if (out_word.flight_us !== want.flight_us)
          note_bad("flight_us", want.flight_us, out_word.flight_us);
        if (out_word.distance_q4 !== want.distance_q4)
          note_bad("distance_q4", want.distance_q4, out_word.distance_q4);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== ultrasonic_tof_ranger_unit.f =====
+incdir+hdl
hdl/utr_pkg.sv
hdl/utr_ctrl.sv
hdl/utr_scale.sv
hdl/ultrasonic_tof_ranger_unit.sv
hdl/utr_checker.sv
tb/tb.sv
